FILE: src/sorted_insert_priority_queue_defines.svh
// assertion macros for the sorted insert priority queue
`ifndef SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold on every rising clock edge outside reset
`define SPQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define SPQ_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SPQ_ASSERT(name, prop, msg)
`define SPQ_ASSERT_NEVER(name, cond, msg)
`endif

`endif

FILE: src/spq_pkg.sv
// shared types and constants for the sorted insert priority queue
`timescale 1ns / 1ps

package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 32;
	localparam int RANK_WIDTH_DEF  = 16;

	// port widths of the request and response fields
	localparam int WORD_PORT_W = 32;
	localparam int RANK_PORT_W = 16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// broadcast command to every cell of the chain
	typedef struct packed {
		logic ins_en;
		logic rem_en;
	} cell_cmd_t;

endpackage

FILE: src/spq_cell.sv
// one slot of the sorted chain: holds an entry, compares and shifts with its neighbors
`timescale 1ns / 1ps

module spq_cell #(
	parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
	parameter int RANK_WIDTH = spq_pkg::RANK_WIDTH_DEF
) (
	input  logic                         clk,
	input  spq_pkg::cell_cmd_t           cmd,
	input  logic [DATA_WIDTH-1:0]        new_word,
	input  logic signed [RANK_WIDTH-1:0] new_rank,
	input  logic                         occupied,
	input  logic                         prev_keep,
	input  logic [DATA_WIDTH-1:0]        prev_word,
	input  logic signed [RANK_WIDTH-1:0] prev_rank,
	input  logic [DATA_WIDTH-1:0]        next_word,
	input  logic signed [RANK_WIDTH-1:0] next_rank,
	output logic                         keep,
	output logic [DATA_WIDTH-1:0]        word,
	output logic signed [RANK_WIDTH-1:0] rank
);

	logic [DATA_WIDTH-1:0]        word_q;
	logic signed [RANK_WIDTH-1:0] rank_q;

	// an entry of equal or higher rank stays ahead of the new one
	assign keep = occupied && (rank_q >= new_rank);
	assign word = word_q;
	assign rank = rank_q;

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (!keep) begin
				if (prev_keep) begin
					word_q <= new_word;
					rank_q <= new_rank;
				end else begin
					word_q <= prev_word;
					rank_q <= prev_rank;
				end
			end
		end else if (cmd.rem_en) begin
			word_q <= next_word;
			rank_q <= next_rank;
		end
	end

endmodule

FILE: src/sorted_insert_priority_queue.sv
// top level of the sorted insert priority queue: chain of cells, count and response register
//
//  channel   signals                                       direction
//  request   req_valid req_stall op data_word rank          in
//  response  rsp_valid rsp_stall removed_word status        out
//            is_empty is_full
//
// for every request all cells compare against the new rank and shift at once,
// so one request per cycle is accepted while the response register is free or being taken.
// the response is registered and appears in the cycle after the request is accepted.
// reset clears the entry count and the response valid; stored entries are left as they are.
// a stalled response holds and stalls further requests.
`timescale 1ns / 1ps

module sorted_insert_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int DATA_WIDTH  = spq_pkg::DATA_WIDTH_DEF,
	parameter int RANK_WIDTH  = spq_pkg::RANK_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  op,
	input  logic [spq_pkg::WORD_PORT_W-1:0]       data_word,
	input  logic signed [spq_pkg::RANK_PORT_W-1:0] rank,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic [spq_pkg::WORD_PORT_W-1:0]       removed_word,
	output logic [1:0]                            status,
	output logic                                  is_empty,
	output logic                                  is_full
);

	`include "sorted_insert_priority_queue_defines.svh"

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int WP    = spq_pkg::WORD_PORT_W;
	localparam int RP    = spq_pkg::RANK_PORT_W;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             rsp_valid_q;
	logic [WP-1:0]    removed_word_q;
	logic [1:0]       status_q;
	logic             is_empty_q;
	logic             is_full_q;

	logic req_accept;
	logic full;
	logic empty;
	logic do_ins;
	logic do_rem;

	logic [DATA_WIDTH-1:0]        new_word;
	logic signed [RANK_WIDTH-1:0] new_rank;
	logic [WP-1:0]                head_word;

	spq_pkg::cell_cmd_t cmd;

	logic [QUEUE_DEPTH-1:0]       keep;
	logic [DATA_WIDTH-1:0]        cell_word [QUEUE_DEPTH];
	logic signed [RANK_WIDTH-1:0] cell_rank [QUEUE_DEPTH];

	assign req_stall  = rsp_valid_q && rsp_stall;
	assign req_accept = req_valid && !req_stall;
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);
	assign do_ins     = req_accept && (op == spq_pkg::OP_INSERT) && !full;
	assign do_rem     = req_accept && (op == spq_pkg::OP_REMOVE) && !empty;
	assign cmd.ins_en = do_ins;
	assign cmd.rem_en = do_rem;

	// fit the request fields to the stored widths
	assign new_word  = DATA_WIDTH'(data_word);
	assign head_word = WP'(cell_word[0]);
	// port bits are taken as they are, upper bits zero
	assign new_rank  = RANK_WIDTH'($unsigned(rank));

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic                         p_keep;
			logic [DATA_WIDTH-1:0]        p_word;
			logic signed [RANK_WIDTH-1:0] p_rank;
			logic [DATA_WIDTH-1:0]        n_word;
			logic signed [RANK_WIDTH-1:0] n_rank;

			if (gi == 0) begin : g_head
				// head cell takes the new entry whenever it does not keep its own
				assign p_keep = 1'b1;
				assign p_word = '0;
				assign p_rank = '0;
			end else begin : g_mid
				assign p_keep = keep[gi-1];
				assign p_word = cell_word[gi-1];
				assign p_rank = cell_rank[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign n_word = '0;
				assign n_rank = '0;
			end else begin : g_body
				assign n_word = cell_word[gi+1];
				assign n_rank = cell_rank[gi+1];
			end

			spq_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.RANK_WIDTH (RANK_WIDTH)
			) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.new_word  (new_word),
				.new_rank  (new_rank),
				.occupied  (count_q > CNT_W'(gi)),
				.prev_keep (p_keep),
				.prev_word (p_word),
				.prev_rank (p_rank),
				.next_word (n_word),
				.next_rank (n_rank),
				.keep      (keep[gi]),
				.word      (cell_word[gi]),
				.rank      (cell_rank[gi])
			);
		end
	endgenerate

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (req_accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			removed_word_q <= do_rem ? head_word : '0;
			is_empty_q     <= (count_next == '0);
			is_full_q      <= (count_next == CNT_W'(QUEUE_DEPTH));
			if (op == spq_pkg::OP_INSERT) begin
				status_q <= full ? spq_pkg::STAT_FULL : spq_pkg::STAT_DONE;
			end else begin
				status_q <= empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_DONE;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign removed_word = removed_word_q;
	assign status       = status_q;
	assign is_empty     = is_empty_q;
	assign is_full      = is_full_q;

	`SPQ_ASSERT_NEVER(a_count_range, count_q > CNT_W'(QUEUE_DEPTH), "entry count past depth")
	`SPQ_ASSERT(a_refused_full,
		rsp_valid_q && status_q == spq_pkg::STAT_FULL |-> is_full_q,
		"refused insert but not full")
	`SPQ_ASSERT(a_refused_empty,
		rsp_valid_q && status_q == spq_pkg::STAT_EMPTY |-> is_empty_q && removed_word_q == '0,
		"refused remove with data")
	`SPQ_ASSERT(a_empty_remove,
		req_accept && op == spq_pkg::OP_REMOVE && empty |=> rsp_valid_q && status_q == spq_pkg::STAT_EMPTY,
		"remove from empty not refused")

endmodule
